FILE: hdl/swfc_pkg.sv
`timescale 1ns / 1ps

package swfc_pkg;

	// ring geometry and field widths
	localparam int RING_DEPTH = 16;
	localparam int CNT_W      = 5;
	localparam int TIME_W     = 48;
	localparam int WIN_W      = 32;
	localparam int THR_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// request codes
	localparam logic [1:0] REQ_FAULT     = 2'd0;
	localparam logic [1:0] REQ_RECONNECT = 2'd1;
	localparam logic [1:0] REQ_CLEAR     = 2'd2;
	localparam logic [1:0] REQ_UNUSED    = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

	// register reset values
	localparam logic [WIN_W-1:0] WIN_RESET = 32'd60000000;
	localparam logic [THR_W-1:0] THR_RESET = 5'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [TIME_W-1:0] event_time;
	} swfc_in_t;

	typedef struct packed {
		logic [CNT_W-1:0] event_count;
		logic             recover_due;
		logic             episode_active;
	} swfc_out_t;

	// controls broadcast to every cell of the chain
	typedef struct packed {
		logic clear;
		logic shift;
		logic append;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRUNE,
		ST_DONE
	} swfc_state_t;

endpackage

FILE: hdl/swfc_cell.sv
`timescale 1ns / 1ps

module swfc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swfc_pkg::cell_ctl_t       ctl,
	input  logic [swfc_pkg::TIME_W-1:0] nxt_stamp,
	input  logic                      nxt_valid,
	input  logic                      prv_valid,
	input  logic [swfc_pkg::TIME_W-1:0] new_stamp,
	output logic [swfc_pkg::TIME_W-1:0] stamp,
	output logic                      valid
);
	import swfc_pkg::*;

	logic [TIME_W-1:0] stamp_q;
	logic              valid_q;
	logic              load;

	// the first empty slot takes the appended stamp
	assign load = ctl.append && !valid_q && prv_valid;

	// valid bit: cleared, shifted toward the oldest end, or set by append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= nxt_valid;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	// stamp payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			stamp_q <= nxt_stamp;
		end else if (load) begin
			stamp_q <= new_stamp;
		end
	end

	assign stamp = stamp_q;
	assign valid = valid_q;

endmodule

FILE: hdl/sliding_window_fault_counter.sv
`timescale 1ns / 1ps
// A reconnect, clear, unused or swallowed fault item goes from idle to the done state; a
//   recording fault item first passes the prune state. No new item is taken until the done
//   state, which waits for a free output register, is left. Pruning shifts the cell chain one
//   stamp per cycle, testing only the oldest cell against the cutoff.
// Reset (arst_n low): window empty, episode closed, registers at 60000000 and 3, no result.

module sliding_window_fault_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  swfc_pkg::swfc_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output swfc_pkg::swfc_out_t           out_data,
	input  logic                          cfg_we,
	input  logic [swfc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [swfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import swfc_pkg::*;

	swfc_state_t       state_q, state_nxt;
	logic [1:0]        req_q;
	logic [TIME_W-1:0] time_q;
	logic              rec_q;
	logic [CNT_W-1:0]  count_q;
	logic              latch_q;
	logic [WIN_W-1:0]  win_q;
	logic [THR_W-1:0]  thr_q;
	logic              out_valid_q;
	swfc_out_t         out_data_q;

	logic              accept;
	logic              go_rec;
	logic              stale;
	logic              out_free;
	logic              shift_en;
	logic              finish;
	logic [CNT_W-1:0]  count_nxt;
	logic              latch_nxt;
	cell_ctl_t         ctl;

	logic [TIME_W-1:0]     stamp_vec [RING_DEPTH];
	logic [RING_DEPTH-1:0] valid_vec;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign go_rec   = (in_data.req_type == REQ_FAULT) && (win_q != '0) && !latch_q;

	// oldest stamp is stale when stamp + window < now, computed without wrap
	assign stale = valid_vec[0] &&
		(({1'b0, stamp_vec[0]} + {{(TIME_W + 1 - WIN_W){1'b0}}, win_q}) <
		 {1'b0, time_q});

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = go_rec ? ST_PRUNE : ST_DONE;
				end
			end
			ST_PRUNE: begin
				if (!stale) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		shift_en = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_PRUNE: shift_en = stale;
			ST_DONE:  finish   = out_free;
			default:  in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= in_data.req_type;
			time_q <= in_data.event_time;
			rec_q  <= go_rec;
		end
	end

	// final action of the item and the status it reports
	always_comb begin
		count_nxt  = count_q;
		latch_nxt  = latch_q;
		ctl.clear  = 1'b0;
		ctl.append = 1'b0;
		ctl.shift  = shift_en;
		if (finish) begin
			case (req_q)
				REQ_FAULT: begin
					if (rec_q) begin
						ctl.append = 1'b1;
						latch_nxt  = 1'b1;
						if (count_q < CNT_W'(RING_DEPTH)) begin
							count_nxt = count_q + 1'b1;
						end
					end
				end
				REQ_RECONNECT: latch_nxt = 1'b0;
				REQ_CLEAR: begin
					ctl.clear = 1'b1;
					count_nxt = '0;
					latch_nxt = 1'b0;
				end
				default: latch_nxt = latch_q;
			endcase
		end
	end

	// held count and episode latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			latch_q <= 1'b0;
		end else if (shift_en) begin
			count_q <= count_q - 1'b1;
		end else begin
			count_q <= count_nxt;
			latch_q <= latch_nxt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WINDOW: win_q <= cfg_wdata[WIN_W-1:0];
				CFG_THRESH: thr_q <= cfg_wdata[THR_W-1:0];
				default:    win_q <= win_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q.event_count    <= count_nxt;
			out_data_q.recover_due    <= (count_nxt >= thr_q);
			out_data_q.episode_active <= latch_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// chain of stamp cells, cell 0 holds the oldest stamp
	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		logic [TIME_W-1:0] nxt_stamp;
		logic              nxt_valid;
		logic              prv_valid;

		if (i == RING_DEPTH - 1) begin : g_last
			assign nxt_stamp = stamp_vec[i];
			assign nxt_valid = 1'b0;
		end else begin : g_mid
			assign nxt_stamp = stamp_vec[i+1];
			assign nxt_valid = valid_vec[i+1];
		end

		if (i == 0) begin : g_first
			assign prv_valid = 1'b1;
		end else begin : g_rest
			assign prv_valid = valid_vec[i-1];
		end

		swfc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.nxt_stamp (nxt_stamp),
			.nxt_valid (nxt_valid),
			.prv_valid (prv_valid),
			.new_stamp (time_q),
			.stamp     (stamp_vec[i]),
			.valid     (valid_vec[i])
		);
	end

`ifndef SYNTHESIS
	// held count tracks the occupied cells
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("held count differs from occupied cells");

	// occupied cells form a run from the oldest end
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((({1'b0, valid_vec} + 1'b1) & {1'b0, valid_vec}) == '0))
		else $error("gap in occupied cells");

	// a result appears only on leaving the done state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside done state");

	// pruning only runs for a recording fault
	a_prune_rec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRUNE |-> rec_q && req_q == REQ_FAULT)
		else $error("prune without a recording fault");
`endif

endmodule
